/* hw/rtl/fps_pkg.sv */
`timescale 1ns / 1ps

package fps_pkg;

   localparam int KIND_W  = 3;
   localparam int IDX_W   = 10;
   localparam int VAL_W   = 64;
   localparam int FOUND_W = 11;
   localparam int SIZE_W  = 11;
   // tree positions run up to twice the largest active size
   localparam int PW      = 12;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   localparam logic [KIND_W-1:0] REQ_ADD    = 3'd0;
   localparam logic [KIND_W-1:0] REQ_SET    = 3'd1;
   localparam logic [KIND_W-1:0] REQ_PREFIX = 3'd2;
   localparam logic [KIND_W-1:0] REQ_RANGE  = 3'd3;
   localparam logic [KIND_W-1:0] REQ_SEARCH = 3'd4;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_PRE_RD,
      S_PRE_ACC,
      S_DELTA,
      S_ADD_RD,
      S_ADD_WR,
      S_SRCH_RD,
      S_SRCH_ACC,
      S_RESP
   } state_type;

   typedef struct packed {
      logic              sub;
      logic [VAL_W-1:0]  a;
      logic [VAL_W-1:0]  b;
      logic [VAL_W-1:0]  limit;
   } alu_op_type;

   function automatic logic [PW-1:0] lowest_bit(input logic [PW-1:0] v);
      return v & (~v + PW'(1));
   endfunction

   function automatic logic [PW-1:0] top_bit(input logic [PW-1:0] v);
      logic [PW-1:0] r;
      r = '0;
      for (int k = 0; k < PW; k++) begin
         if (v[k]) r = PW'(1) << k;
      end
      return r;
   endfunction

endpackage

/* hw/rtl/fps_req_if.sv */
`timescale 1ns / 1ps

interface fps_req_if;
   logic                                    valid;
   logic                                    ready;
   logic        [fps_pkg::KIND_W-1:0]       req_type;
   logic        [fps_pkg::IDX_W-1:0]        index;
   logic        [fps_pkg::IDX_W-1:0]        lo_index;
   logic signed [fps_pkg::VAL_W-1:0]        operand_value;

   modport source (output valid, output req_type, output index, output lo_index,
                   output operand_value, input ready);
   modport sink   (input valid, input req_type, input index, input lo_index,
                   input operand_value, output ready);
endinterface

/* hw/rtl/fps_rsp_if.sv */
`timescale 1ns / 1ps

interface fps_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [fps_pkg::VAL_W-1:0]        sum_value;
   logic signed [fps_pkg::FOUND_W-1:0]      found_index;
   logic                                    status;

   modport source (output valid, output sum_value, output found_index, output status,
                   input ready);
   modport sink   (input valid, input sum_value, input found_index, input status,
                   output ready);
endinterface

/* hw/rtl/fps_csr_if.sv */
`timescale 1ns / 1ps

interface fps_csr_if;
   logic                              valid;
   logic                              ready;
   logic [fps_pkg::SIZE_W-1:0]        active_size;

   modport source (output valid, output active_size, input ready);
   modport sink   (input valid, input active_size, output ready);
endinterface

/* hw/rtl/fps_ram.sv */
`timescale 1ns / 1ps

module fps_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/fps_alu.sv */
`timescale 1ns / 1ps

module fps_alu (
   input  fps_pkg::alu_op_type              op,
   output logic [fps_pkg::VAL_W-1:0]        sum,
   output logic                             le
);
   import fps_pkg::*;

   logic [VAL_W-1:0] b_eff;

   assign b_eff = op.sub ? ~op.b : op.b;
   assign sum   = op.a + b_eff + VAL_W'(op.sub);
   assign le    = $signed(sum) <= $signed(op.limit);

endmodule

/* hw/rtl/fps_ctrl.sv */
`timescale 1ns / 1ps

module fps_ctrl #(
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   fps_req_if.sink                          req,
   fps_rsp_if.source                        rsp,
   input  logic [fps_pkg::PW-1:0]           size_n,
   input  logic [fps_pkg::PW-1:0]           size_top,
   output logic                             ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]         ram_wr_addr,
   output logic [fps_pkg::VAL_W-1:0]        ram_wr_data,
   output logic                             ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]         ram_rd_addr,
   input  logic [fps_pkg::VAL_W-1:0]        ram_rd_data,
   output fps_pkg::alu_op_type              alu_op,
   input  logic [fps_pkg::VAL_W-1:0]        alu_sum,
   input  logic                             alu_le
);
   import fps_pkg::*;

   localparam int AW = $clog2(DEPTH);

   state_type            state_ff, state_in;
   logic [KIND_W-1:0]    kind_ff, kind_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     lo_ff, lo_in;
   logic [VAL_W-1:0]     opnd_ff, opnd_in;
   logic [VAL_W-1:0]     acc_ff, acc_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [PW-1:0]        bit_ff, bit_in;
   logic                 pass_ff, pass_in;
   logic                 err_ff, err_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]     rsp_sum_ff, rsp_sum_in;
   logic [FOUND_W-1:0]   rsp_found_ff, rsp_found_in;
   logic                 rsp_status_ff, rsp_status_in;

   logic                 req_err;
   logic [PW-1:0]        first_pos;
   logic [PW-1:0]        pos_dec;
   logic [PW-1:0]        pos_inc;
   logic [PW-1:0]        probe;
   logic                 probe_ok;
   logic [PW-1:0]        bit_nx;
   logic                 two_pass;
   logic [PW-1:0]        second_pos;
   logic                 rsp_free;
   logic                 keep_sum;

   assign first_pos  = PW'(req.index) + PW'(1);
   assign pos_dec    = pos_ff - lowest_bit(pos_ff);
   assign pos_inc    = pos_ff + lowest_bit(pos_ff);
   assign probe      = pos_ff + bit_ff;
   assign probe_ok   = probe <= size_n;
   assign bit_nx     = bit_ff >> 1;
   assign two_pass   = (kind_ff == REQ_RANGE) || (kind_ff == REQ_SET);
   assign second_pos = (kind_ff == REQ_RANGE) ? PW'(lo_ff) : PW'(idx_ff);
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign keep_sum   = !err_ff && ((kind_ff == REQ_PREFIX) || (kind_ff == REQ_RANGE) ||
                                   (kind_ff == REQ_SEARCH));

   always_comb begin
      case (req.req_type) inside
         REQ_ADD, REQ_SET, REQ_PREFIX: req_err = PW'(req.index) >= size_n;
         REQ_RANGE: req_err = (PW'(req.index) >= size_n) || (PW'(req.lo_index) >= size_n);
         default:   req_err = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == AW'(DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req.valid) begin
               if (req_err) begin
                  state_in = S_RESP;
               end else begin
                  case (req.req_type) inside
                     REQ_ADD:                      state_in = S_ADD_RD;
                     REQ_SET, REQ_PREFIX, REQ_RANGE: state_in = S_PRE_RD;
                     REQ_SEARCH:                   state_in = S_SRCH_RD;
                     default:                      state_in = S_RESP;
                  endcase
               end
            end
         end
         S_PRE_RD: state_in = S_PRE_ACC;
         S_PRE_ACC: begin
            if (pos_dec != '0) begin
               state_in = S_PRE_RD;
            end else if (!pass_ff && two_pass && second_pos != '0) begin
               state_in = S_PRE_RD;
            end else begin
               state_in = (kind_ff == REQ_SET) ? S_DELTA : S_RESP;
            end
         end
         S_DELTA:  state_in = S_ADD_RD;
         S_ADD_RD: state_in = S_ADD_WR;
         S_ADD_WR: state_in = (pos_inc <= size_n) ? S_ADD_RD : S_RESP;
         S_SRCH_RD: begin
            if (probe_ok)             state_in = S_SRCH_ACC;
            else if (bit_nx == '0)    state_in = S_RESP;
         end
         S_SRCH_ACC: state_in = (bit_nx == '0) ? S_RESP : S_SRCH_RD;
         S_RESP: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      kind_in       = kind_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      opnd_in       = opnd_ff;
      acc_in        = acc_ff;
      pos_in        = pos_ff;
      bit_in        = bit_ff;
      pass_in       = pass_ff;
      err_in        = err_ff;
      clr_in        = clr_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = AW'(pos_ff - PW'(1));
      ram_wr_data   = alu_sum;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = AW'(pos_ff - PW'(1));
      alu_op.sub    = 1'b0;
      alu_op.a      = acc_ff;
      alu_op.b      = ram_rd_data;
      alu_op.limit  = opnd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_sum_in    = rsp_sum_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
            clr_in      = clr_ff + AW'(1);
         end
         S_IDLE: begin
            if (req.valid) begin
               kind_in = req.req_type;
               idx_in  = req.index;
               lo_in   = req.lo_index;
               opnd_in = req.operand_value;
               acc_in  = '0;
               pass_in = 1'b0;
               err_in  = req_err;
               bit_in  = size_top;
               pos_in  = (req.req_type == REQ_SEARCH) ? '0 : first_pos;
            end
         end
         S_PRE_RD: ram_rd_en = 1'b1;
         S_PRE_ACC: begin
            alu_op.sub = pass_ff;
            acc_in     = alu_sum;
            pos_in     = pos_dec;
            if (pos_dec == '0 && !pass_ff && two_pass) begin
               pass_in = 1'b1;
               pos_in  = second_pos;
            end
         end
         S_DELTA: begin
            alu_op.sub = 1'b1;
            alu_op.a   = opnd_ff;
            alu_op.b   = acc_ff;
            opnd_in    = alu_sum;
            pos_in     = PW'(idx_ff) + PW'(1);
         end
         S_ADD_RD: ram_rd_en = 1'b1;
         S_ADD_WR: begin
            alu_op.a  = ram_rd_data;
            alu_op.b  = opnd_ff;
            ram_wr_en = 1'b1;
            pos_in    = pos_inc;
         end
         S_SRCH_RD: begin
            ram_rd_addr = AW'(probe - PW'(1));
            if (probe_ok) ram_rd_en = 1'b1;
            else          bit_in    = bit_nx;
         end
         S_SRCH_ACC: begin
            if (alu_le) begin
               acc_in = alu_sum;
               pos_in = probe;
            end
            bit_in = bit_nx;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sum_in    = keep_sum ? acc_ff : '0;
               rsp_found_in  = (kind_ff == REQ_SEARCH) ? FOUND_W'(pos_ff - PW'(1)) : '1;
               rsp_status_in = err_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      idx_ff        <= idx_in;
      lo_ff         <= lo_in;
      opnd_ff       <= opnd_in;
      acc_ff        <= acc_in;
      pos_ff        <= pos_in;
      bit_ff        <= bit_in;
      pass_ff       <= pass_in;
      err_ff        <= err_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req.ready       = (state_ff == S_IDLE);
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.sum_value   = rsp_sum_ff;
   assign rsp.found_index = rsp_found_ff;
   assign rsp.status      = rsp_status_ff;

   a_add_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ADD_WR |-> pos_ff != '0 && pos_ff <= size_n)
      else $error("update walk left the active tree");

   a_prefix_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PRE_RD |-> pos_ff != '0)
      else $error("prefix walk read at position zero");

   a_search_bit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH_RD || state_ff == S_SRCH_ACC |-> $onehot(bit_ff))
      else $error("search step is not a single power of two");

   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP && rsp_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("finished request not presented");

endmodule

/* hw/rtl/fenwick_prefix_sum_tree.sv */
`timescale 1ns / 1ps

// Binary indexed tree of 64-bit partial sums serving add, set, prefix sum, range sum and
// prefix search requests, one request at a time. After reset the store is cleared by a
// pass over all DEPTH entries, one entry a cycle, during which no request is taken
// (active_size writes are). A request is then accepted, visits tree nodes (each visit a
// registered memory read followed by the shared 64-bit adder), and posts its response:
// a prefix sum visits up to log2(n)+1 nodes, a range sum two such walks, set two prefix
// walks, a delta step and an update walk, add one update walk, and a search log2(n)+1
// probes. Out-of-range and unknown requests go from acceptance straight to the response.
// The response sits in its own register, so the next request is accepted while it
// waits.

module fenwick_prefix_sum_tree #(
   parameter int DEPTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   fps_req_if.sink    req,
   fps_rsp_if.source  rsp,
   fps_csr_if.sink    csr
);
   import fps_pkg::*;

   localparam int AW   = $clog2(DEPTH);
   localparam int NCAP = (DEPTH > 2047) ? 2047 : DEPTH;

   logic [SIZE_W-1:0] active_size_ff, active_size_in;
   logic [PW-1:0]     size_n;
   logic [PW-1:0]     size_top;
   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [VAL_W-1:0]  ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [VAL_W-1:0]  ram_rd_data;
   alu_op_type        alu_op;
   logic [VAL_W-1:0]  alu_sum;
   logic              alu_le;

   assign csr.ready      = 1'b1;
   assign active_size_in = csr.valid ? csr.active_size : active_size_ff;

   always_ff @(posedge clock) begin
      if (reset) active_size_ff <= SIZE_RESET;
      else       active_size_ff <= active_size_in;
   end

   always_comb begin
      if (active_size_ff == '0)                 size_n = PW'(1);
      else if (PW'(active_size_ff) > PW'(NCAP)) size_n = PW'(NCAP);
      else                                      size_n = PW'(active_size_ff);
   end

   assign size_top = top_bit(size_n);

   fps_ram #(
      .WIDTH (VAL_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fps_alu u_alu (
      .op  (alu_op),
      .sum (alu_sum),
      .le  (alu_le)
   );

   fps_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .size_n      (size_n),
      .size_top    (size_top),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .alu_op      (alu_op),
      .alu_sum     (alu_sum),
      .alu_le      (alu_le)
   );

endmodule
